// ===== rtl/bgp_fsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bgp_fsm_pkg
// shared widths, session state codes, timer commands and word layouts for the
// bgp session state machine
// ----------------------------------------------------------------------------
package bgp_fsm_pkg;

	localparam int COUNT_WIDTH = 32;  // default width of the wrapping counters
	localparam int OUT_CNT_W   = 32;  // counter width seen on the result word
	localparam int OP_W        = 4;
	localparam int STATE_W     = 3;
	localparam int RT_CMD_W    = 2;
	localparam int HOLD_W      = 16;

	localparam logic [HOLD_W-1:0] HOLD_TIME_RST = HOLD_W'(180);

	// session state codes as shown on the result word
	localparam logic [STATE_W-1:0] SESSION_IDLE        = 3'd0;
	localparam logic [STATE_W-1:0] SESSION_CONNECT     = 3'd1;
	localparam logic [STATE_W-1:0] SESSION_ACTIVE      = 3'd2;
	localparam logic [STATE_W-1:0] SESSION_OPENSENT    = 3'd3;
	localparam logic [STATE_W-1:0] SESSION_OPENCONFIRM = 3'd4;
	localparam logic [STATE_W-1:0] SESSION_ESTABLISHED = 3'd5;

	// connect retry timer commands
	localparam logic [RT_CMD_W-1:0] RT_NONE    = 2'd0;
	localparam logic [RT_CMD_W-1:0] RT_RESTART = 2'd1;
	localparam logic [RT_CMD_W-1:0] RT_STOP    = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            retry_timer_running;
	} evt_word_t;

	typedef struct packed {
		logic [STATE_W-1:0]   session_state;
		logic [RT_CMD_W-1:0]  retry_timer_cmd;
		logic                 abort_connection;
		logic                 open_tcp;
		logic                 listen_peer;
		logic                 send_open;
		logic                 send_keepalive;
		logic                 restart_hold_timer;
		logic                 restart_keepalive_timer;
		logic                 entered_established;
		logic [OUT_CNT_W-1:0] retry_count;
		logic [OUT_CNT_W-1:0] msg_count;
	} res_word_t;

endpackage

// ===== rtl/bgp_valid_ready_if.sv =====
// ----------------------------------------------------------------------------
// bgp_valid_ready_if
// valid/ready channel carrying one word of a given type
// ----------------------------------------------------------------------------
interface bgp_valid_ready_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bgp_session_fsm.sv =====
// ----------------------------------------------------------------------------
// bgp_session_fsm
// session state machine for one bgp peer: one event word in, one result word
// out with the new state, command pulses and counters
// ----------------------------------------------------------------------------
//
//  channel | dir | word                         | taken when
//  --------+-----+------------------------------+----------------------------
//  evt     | in  | op, retry_timer_running      | evt.valid && evt.ready
//  res     | out | state, commands, counters    | res.valid && res.ready
//  cfg     | in  | hold_time (16 bits)          | cfg.valid && cfg.ready
//
//  an event is captured in the input register; when it moves on, the state logic
//  updates state and counters and loads the result register at the same edge
//  one event per cycle is sustained while res is taken; each event passes the input and result registers
//  reset: state idle, counters zero, hold_time 180, both stages empty
//  a stalled res word holds; evt.ready drops only when both stages are full
//  and res is not taken; cfg is always ready
// ----------------------------------------------------------------------------
module bgp_session_fsm #(
	parameter int COUNT_WIDTH = bgp_fsm_pkg::COUNT_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	bgp_valid_ready_if.sink           evt,
	bgp_valid_ready_if.source         res,
	bgp_valid_ready_if.sink           cfg
);

	localparam int OUT_W = bgp_fsm_pkg::OUT_CNT_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	typedef enum logic [bgp_fsm_pkg::STATE_W-1:0] {
		ST_IDLE        = bgp_fsm_pkg::SESSION_IDLE,
		ST_CONNECT     = bgp_fsm_pkg::SESSION_CONNECT,
		ST_ACTIVE      = bgp_fsm_pkg::SESSION_ACTIVE,
		ST_OPENSENT    = bgp_fsm_pkg::SESSION_OPENSENT,
		ST_OPENCONFIRM = bgp_fsm_pkg::SESSION_OPENCONFIRM,
		ST_ESTABLISHED = bgp_fsm_pkg::SESSION_ESTABLISHED
	} state_t;

	typedef enum logic [bgp_fsm_pkg::OP_W-1:0] {
		OP_START       = 4'd0,
		OP_RETRY_EXP   = 4'd1,
		OP_HOLD_EXP    = 4'd2,
		OP_KA_EXP      = 4'd3,
		OP_TCP_OK      = 4'd4,
		OP_TCP_FAIL    = 4'd5,
		OP_OPEN_MSG    = 4'd6,
		OP_KA_MSG      = 4'd7,
		OP_UPDATE_MSG  = 4'd8
	} op_t;

	// input register
	logic                      valid_s1;
	bgp_fsm_pkg::evt_word_t    evt_s1;

	// session state and counters
	state_t                    state_q;
	logic [COUNT_WIDTH-1:0]    retry_q;
	logic [COUNT_WIDTH-1:0]    open_cnt_q;
	logic [COUNT_WIDTH-1:0]    ka_cnt_q;
	logic [COUNT_WIDTH-1:0]    upd_cnt_q;
	logic [bgp_fsm_pkg::HOLD_W-1:0] hold_time_q;

	// result register
	logic                      res_valid_q;
	bgp_fsm_pkg::res_word_t    res_q;

	// handshake
	logic                      evt_take;
	logic                      advance;

	// next-state logic
	state_t                    state_nxt;
	op_t                       op;
	logic [bgp_fsm_pkg::RT_CMD_W-1:0] rt_cmd;
	logic                      abort_c;
	logic                      open_t;
	logic                      listen;
	logic                      s_open;
	logic                      s_ka;
	logic                      r_hold;
	logic                      r_ka;
	logic                      fail;
	logic                      fail_stop;
	logic                      handled_msg;
	logic                      is_msg;
	logic                      clr_retry;
	logic [COUNT_WIDTH-1:0]    retry_nxt;
	logic [COUNT_WIDTH-1:0]    msg_cur;
	logic [COUNT_WIDTH-1:0]    msg_nxt;
	logic [OUT_W-1:0]          retry_out;
	logic [OUT_W-1:0]          msg_out;

	// the word in the input register moves on when the result slot is free
	// or being emptied in this cycle
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready = !valid_s1 || advance;
	assign evt_take  = evt.valid && evt.ready;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	assign op = op_t'(evt_s1.op);

	// event decode per state; failing cases are flagged and merged below
	always_comb begin
		state_nxt   = state_q;
		rt_cmd      = bgp_fsm_pkg::RT_NONE;
		abort_c     = 1'b0;
		open_t      = 1'b0;
		listen      = 1'b0;
		s_open      = 1'b0;
		s_ka        = 1'b0;
		r_hold      = 1'b0;
		r_ka        = 1'b0;
		fail        = 1'b0;
		fail_stop   = 1'b0;
		handled_msg = 1'b0;
		clr_retry   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (op == OP_START) begin
					clr_retry = 1'b1;
					rt_cmd    = bgp_fsm_pkg::RT_RESTART;
					listen    = 1'b1;
					open_t    = 1'b1;
					state_nxt = ST_CONNECT;
				end
			end
			ST_CONNECT: begin
				case (op)
					OP_RETRY_EXP: begin
						abort_c = 1'b1;
						rt_cmd  = bgp_fsm_pkg::RT_RESTART;
						open_t  = 1'b1;
					end
					OP_HOLD_EXP, OP_KA_EXP: begin
						fail      = 1'b1;
						fail_stop = evt_s1.retry_timer_running;
					end
					OP_TCP_OK: begin
						rt_cmd    = bgp_fsm_pkg::RT_STOP;
						s_open    = 1'b1;
						r_hold    = 1'b1;
						state_nxt = ST_OPENSENT;
					end
					OP_TCP_FAIL: state_nxt = ST_ACTIVE;
					OP_KA_MSG, OP_UPDATE_MSG: begin
						handled_msg = 1'b1;
						fail        = 1'b1;
						fail_stop   = evt_s1.retry_timer_running;
					end
					default: ;
				endcase
			end
			ST_ACTIVE: begin
				case (op)
					OP_RETRY_EXP: begin
						rt_cmd    = bgp_fsm_pkg::RT_RESTART;
						open_t    = 1'b1;
						state_nxt = ST_CONNECT;
					end
					OP_HOLD_EXP, OP_KA_EXP: begin
						fail      = 1'b1;
						fail_stop = 1'b1;
					end
					OP_TCP_OK: begin
						rt_cmd    = bgp_fsm_pkg::RT_STOP;
						s_open    = 1'b1;
						r_hold    = 1'b1;
						state_nxt = ST_OPENSENT;
					end
					OP_TCP_FAIL: state_nxt = ST_IDLE;
					OP_OPEN_MSG, OP_KA_MSG, OP_UPDATE_MSG: begin
						handled_msg = 1'b1;
						fail        = 1'b1;
						fail_stop   = 1'b1;
					end
					default: ;
				endcase
			end
			ST_OPENSENT: begin
				case (op)
					OP_RETRY_EXP, OP_HOLD_EXP, OP_KA_EXP: begin
						fail      = 1'b1;
						fail_stop = 1'b1;
					end
					OP_TCP_FAIL: begin
						abort_c   = 1'b1;
						rt_cmd    = bgp_fsm_pkg::RT_RESTART;
						listen    = 1'b1;
						state_nxt = ST_ACTIVE;
					end
					OP_OPEN_MSG: begin
						handled_msg = 1'b1;
						rt_cmd      = bgp_fsm_pkg::RT_STOP;
						s_ka        = 1'b1;
						r_ka        = 1'b1;
						r_hold      = 1'b1;
						state_nxt   = ST_OPENCONFIRM;
					end
					OP_KA_MSG, OP_UPDATE_MSG: begin
						handled_msg = 1'b1;
						fail        = 1'b1;
						fail_stop   = 1'b1;
					end
					default: ;
				endcase
			end
			ST_OPENCONFIRM: begin
				case (op)
					OP_RETRY_EXP, OP_HOLD_EXP: begin
						fail      = 1'b1;
						fail_stop = 1'b1;
					end
					OP_KA_EXP: begin
						s_ka = 1'b1;
						r_ka = 1'b1;
					end
					OP_TCP_FAIL: state_nxt = ST_IDLE;
					OP_KA_MSG: begin
						handled_msg = 1'b1;
						r_hold      = 1'b1;
						state_nxt   = ST_ESTABLISHED;
					end
					OP_OPEN_MSG, OP_UPDATE_MSG: begin
						handled_msg = 1'b1;
						fail        = 1'b1;
						fail_stop   = 1'b1;
					end
					default: ;
				endcase
			end
			ST_ESTABLISHED: begin
				case (op)
					OP_RETRY_EXP, OP_HOLD_EXP: begin
						fail      = 1'b1;
						fail_stop = 1'b1;
					end
					OP_KA_EXP: begin
						s_ka = 1'b1;
						// zero hold time means no keepalive timer
						r_ka = (hold_time_q != '0);
					end
					OP_OPEN_MSG: handled_msg = 1'b1;
					OP_KA_MSG, OP_UPDATE_MSG: begin
						handled_msg = 1'b1;
						r_hold      = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// session failure: drop to idle, abort, count a retry
		if (fail) begin
			abort_c   = 1'b1;
			state_nxt = ST_IDLE;
			if (fail_stop) begin
				rt_cmd = bgp_fsm_pkg::RT_STOP;
			end
		end
	end

	always_comb begin
		if (clr_retry) begin
			retry_nxt = '0;
		end else if (fail) begin
			retry_nxt = retry_q + CNT_ONE;
		end else begin
			retry_nxt = retry_q;
		end
	end

	// message counter of the received kind; unhandled messages only report it
	always_comb begin
		is_msg = 1'b1;
		case (op)
			OP_OPEN_MSG:   msg_cur = open_cnt_q;
			OP_KA_MSG:     msg_cur = ka_cnt_q;
			OP_UPDATE_MSG: msg_cur = upd_cnt_q;
			default: begin
				is_msg  = 1'b0;
				msg_cur = '0;
			end
		endcase
		msg_nxt = handled_msg ? (msg_cur + CNT_ONE) : msg_cur;
	end

	// counters reach the result word zero-extended or truncated to its width
	generate
		if (COUNT_WIDTH >= OUT_W) begin : g_cnt_trunc
			assign retry_out = retry_nxt[OUT_W-1:0];
			assign msg_out   = msg_nxt[OUT_W-1:0];
		end else begin : g_cnt_ext
			assign retry_out = {{(OUT_W-COUNT_WIDTH){1'b0}}, retry_nxt};
			assign msg_out   = {{(OUT_W-COUNT_WIDTH){1'b0}}, msg_nxt};
		end
	endgenerate

	// input register, session state, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			evt_s1      <= '0;
			state_q     <= ST_IDLE;
			retry_q     <= '0;
			open_cnt_q  <= '0;
			ka_cnt_q    <= '0;
			upd_cnt_q   <= '0;
			hold_time_q <= bgp_fsm_pkg::HOLD_TIME_RST;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg.valid) begin
				hold_time_q <= cfg.data;
			end

			if (evt_take) begin
				evt_s1 <= evt.data;
			end
			if (evt.ready) begin
				valid_s1 <= evt.valid;
			end

			// a new word refills the slot, else a taken word empties it
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			if (advance) begin
				state_q   <= state_nxt;
				retry_q   <= retry_nxt;
				if (handled_msg) begin
					case (op)
						OP_OPEN_MSG:   open_cnt_q <= msg_nxt;
						OP_KA_MSG:     ka_cnt_q   <= msg_nxt;
						OP_UPDATE_MSG: upd_cnt_q  <= msg_nxt;
						default: ;
					endcase
				end
				res_q.session_state           <= state_nxt;
				res_q.retry_timer_cmd         <= rt_cmd;
				res_q.abort_connection        <= abort_c;
				res_q.open_tcp                <= open_t;
				res_q.listen_peer             <= listen;
				res_q.send_open               <= s_open;
				res_q.send_keepalive          <= s_ka;
				res_q.restart_hold_timer      <= r_hold;
				res_q.restart_keepalive_timer <= r_ka;
				res_q.entered_established     <= (state_nxt == ST_ESTABLISHED) &&
				                                 (state_q != ST_ESTABLISHED);
				res_q.retry_count             <= retry_out;
				res_q.msg_count               <= is_msg ? msg_out : '0;
			end
		end
	end

endmodule

// ===== rtl/bgp_fsm_checker.sv =====
// ----------------------------------------------------------------------------
// bgp_fsm_checker
// port-level checks on the result word of the bgp session state machine
// ----------------------------------------------------------------------------
module bgp_fsm_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input bgp_fsm_pkg::res_word_t res_data
);

	// entry pulse only together with the established state
	a_entry_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.entered_established |->
		res_data.session_state == bgp_fsm_pkg::SESSION_ESTABLISHED)
		else $error("entry pulse outside established");

	// timer command is one of the three defined codes
	a_rt_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
		res_data.retry_timer_cmd == bgp_fsm_pkg::RT_NONE ||
		res_data.retry_timer_cmd == bgp_fsm_pkg::RT_RESTART ||
		res_data.retry_timer_cmd == bgp_fsm_pkg::RT_STOP)
		else $error("undefined retry timer command");

	// an open goes out only on the move to opensent
	a_open_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.send_open |->
		res_data.session_state == bgp_fsm_pkg::SESSION_OPENSENT)
		else $error("open sent outside opensent");

	// listening starts only on the way into connect or active
	a_listen_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.listen_peer |->
		res_data.session_state == bgp_fsm_pkg::SESSION_CONNECT ||
		res_data.session_state == bgp_fsm_pkg::SESSION_ACTIVE)
		else $error("listen outside connect or active");

	// a stalled result word stays
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result word dropped or changed under stall");

endmodule

bind bgp_session_fsm bgp_fsm_checker u_bgp_fsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
